### rtl/core/kfcv_pkg.sv
// Package for the constant-velocity Kalman filter core.
// Holds word sizes, reset values and operation codes; no dependencies.
package kfcv_pkg;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int CFG_WIDTH      = 31;
    localparam int CFG_IDX_WIDTH  = 1;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_PROCESS_NOISE = 1'b0;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_MEASURE_NOISE = 1'b1;
    localparam logic FUNC_PREDICT = 1'b0;
    localparam logic FUNC_UPDATE  = 1'b1;
    localparam logic [CFG_WIDTH-1:0] PROCESS_NOISE_RST = 31'd6554;
    localparam logic [CFG_WIDTH-1:0] MEASURE_NOISE_RST = 31'd65536;
endpackage

### rtl/core/kfcv_in_if.sv
// Input channel: valid/ready with func and measurement.
// Depends on nothing.
interface kfcv_in_if #(parameter int DW = 32);
    logic          valid;
    logic          ready;
    logic          func;
    logic [DW-1:0] measurement;
    modport source (output valid, func, measurement, input ready);
    modport sink   (input valid, func, measurement, output ready);
endinterface

### rtl/core/kfcv_out_if.sv
// Output channel: valid/ready with position, velocity and saturation flag.
// Depends on nothing.
interface kfcv_out_if #(parameter int DW = 32);
    logic          valid;
    logic          ready;
    logic [DW-1:0] position;
    logic [DW-1:0] velocity;
    logic          saturated;
    modport source (output valid, position, velocity, saturated, input ready);
    modport sink   (input valid, position, velocity, saturated, output ready);
endinterface

### rtl/core/kalman_filter_const_velocity_unit.sv
// Constant-velocity Kalman filter core, iterative with one shared datapath.
// Depends on kfcv_pkg, kfcv_in_if and kfcv_out_if.
//
// Channel  Dir  Fields                               Transfer
// s_in     in   func, measurement                    valid & ready
// m_out    out  position, velocity, saturated        valid & ready
// cfg      in   i_cfg_we, i_cfg_idx, i_cfg_data      write enable high
//
// Predict runs from the accepting edge to a valid result as eight saturating
// adds on the shared adder, one per cycle, then the output load.
// Update runs two adds, two restoring divides of DATA_WIDTH+FRAC_BITS quotient
// bits with a finishing step each, six multiplies (each a registered product,
// then round/clamp/add), then the output load. The result is held in an output
// register; the next item is accepted once it is taken. Reset is synchronous
// and restores state and registers; no clearing pass.
module kalman_filter_const_velocity_unit
    import kfcv_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_WIDTH-1:0] i_cfg_idx,
    input  logic [CFG_WIDTH-1:0]     i_cfg_data,
    kfcv_in_if.sink                  s_in,
    kfcv_out_if.source               m_out
);
    localparam int DW  = DATA_WIDTH;
    localparam int NW  = DW + FRAC_BITS;            // dividend width
    localparam int CW  = $clog2(NW + 1);
    localparam int PW  = 2 * DW;
    localparam logic signed [DW-1:0] HI = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] LO = {1'b1, {(DW-1){1'b0}}};
    localparam logic signed [DW-1:0] ONE = DW'(1) <<< FRAC_BITS;

    // sequencer codes
    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_P0    = 5'd1;  // pos += vel
    localparam logic [4:0] ST_P1    = 5'd2;  // t = pp + pv
    localparam logic [4:0] ST_P2    = 5'd3;  // t += vp
    localparam logic [4:0] ST_P3    = 5'd4;  // t += vv
    localparam logic [4:0] ST_P4    = 5'd5;  // t += q
    localparam logic [4:0] ST_P5    = 5'd6;  // pv += vv
    localparam logic [4:0] ST_P6    = 5'd7;  // vp += vv
    localparam logic [4:0] ST_P7    = 5'd8;  // vv += q, pp = t
    localparam logic [4:0] ST_U0    = 5'd9;  // S = pp + r
    localparam logic [4:0] ST_U1    = 5'd10; // y = z - pos, start div k0
    localparam logic [4:0] ST_DIV   = 5'd11;
    localparam logic [4:0] ST_DEND  = 5'd12;
    localparam logic [4:0] ST_MUL   = 5'd13; // product registered
    localparam logic [4:0] ST_ACC   = 5'd14; // round, clamp, subtract/add
    localparam logic [4:0] ST_OUT   = 5'd15;

    logic [4:0] r_st, n_st;
    logic signed [DW-1:0] r_pos, r_vel, r_pp, r_pv, r_vp, r_vv;
    logic signed [DW-1:0] r_t, r_s, r_y, r_k0, r_k1, r_z;
    logic [CFG_WIDTH-1:0] r_q, r_r;
    logic r_sat, r_kidx;
    logic [2:0] r_mi;
    logic [NW-1:0] r_num;
    logic [DW:0]   r_rem;
    logic [NW-1:0] r_quo;
    logic [DW-1:0] r_dmag;
    logic          r_qneg;
    logic [CW-1:0] r_cnt;
    logic [PW-1:0] r_prod;
    logic          r_pneg;
    logic          r_ovalid;
    logic signed [DW-1:0] r_opos, r_ovel;
    logic          r_osat;

    // register value with clamp to the word
    function automatic logic signed [DW-1:0] reg_w(input logic [CFG_WIDTH-1:0] v);
        logic [63:0] e;
        e = 64'(v);
        if (e > 64'(HI)) return HI;
        return DW'(e);
    endfunction

    // shared saturating adder
    logic signed [DW-1:0] a_x, a_y, a_res;
    logic a_sub, a_ovf;
    logic signed [DW:0] a_full;
    always_comb begin
        a_full = a_sub ? ({a_x[DW-1], a_x} - {a_y[DW-1], a_y})
                       : ({a_x[DW-1], a_x} + {a_y[DW-1], a_y});
        a_ovf  = a_full[DW] != a_full[DW-1];
        a_res  = a_ovf ? (a_full[DW] ? LO : HI) : a_full[DW-1:0];
    end

    // multiply operand and accumulate target selection
    logic signed [DW-1:0] m_a, m_b, m_acc;
    always_comb begin
        m_a = r_k0; m_b = r_y; m_acc = r_pos;
        case (r_mi)
            3'd0: begin m_a = r_k0; m_b = r_y;  m_acc = r_pos; end
            3'd1: begin m_a = r_k1; m_b = r_y;  m_acc = r_vel; end
            3'd2: begin m_a = r_k1; m_b = r_pp; m_acc = r_vp;  end
            3'd3: begin m_a = r_k1; m_b = r_pv; m_acc = r_vv;  end
            3'd4: begin m_a = r_k0; m_b = r_pp; m_acc = r_pp;  end
            3'd5: begin m_a = r_k0; m_b = r_pv; m_acc = r_pv;  end
            default: begin m_a = r_k0; m_b = r_y; m_acc = r_pos; end
        endcase
    end
    logic [DW-1:0] ma_mag, mb_mag;
    assign ma_mag = m_a[DW-1] ? DW'(-m_a) : DW'(m_a);
    assign mb_mag = m_b[DW-1] ? DW'(-m_b) : DW'(m_b);

    // round half away, clamp magnitude
    logic [PW-1:0] rnd;
    logic [PW-1:0] rsh;
    logic signed [DW-1:0] m_val;
    logic m_ovf;
    always_comb begin
        rnd = r_prod + (PW'(1) << (FRAC_BITS - 1));
        rsh = rnd >> FRAC_BITS;
        m_ovf = 1'b0;
        if (r_pneg) begin
            if (rsh > PW'(HI) + PW'(1)) begin m_val = LO; m_ovf = 1'b1; end
            else m_val = DW'(-rsh);
        end else begin
            if (rsh > PW'(HI)) begin m_val = HI; m_ovf = 1'b1; end
            else m_val = DW'(rsh);
        end
    end

    // divider step: numerator magnitude shifted in msb first
    logic [DW:0] d_try;
    logic [DW:0] d_sh;
    assign d_sh  = {r_rem[DW-1:0], r_num[NW-1]};
    assign d_try = d_sh - {1'b0, r_dmag};
    logic signed [DW-1:0] num_sel;
    assign num_sel = r_kidx ? r_vp : r_pp;
    logic [DW-1:0] num_mag, s_mag;
    assign num_mag = num_sel[DW-1] ? DW'(-num_sel) : DW'(num_sel);
    assign s_mag   = r_s[DW-1] ? DW'(-r_s) : DW'(r_s);

    // quotient clamp
    logic signed [DW-1:0] q_val;
    logic q_ovf;
    always_comb begin
        q_ovf = 1'b0;
        if (r_qneg) begin
            if (r_quo > NW'(HI) + NW'(1)) begin q_val = LO; q_ovf = 1'b1; end
            else q_val = DW'(-r_quo);
        end else begin
            if (r_quo > NW'(HI)) begin q_val = HI; q_ovf = 1'b1; end
            else q_val = DW'(r_quo);
        end
    end

    // adder operand choice per state
    always_comb begin
        a_x = r_pos; a_y = r_vel; a_sub = 1'b0;
        case (r_st)
            ST_P0:  begin a_x = r_pos; a_y = r_vel; end
            ST_P1:  begin a_x = r_pp;  a_y = r_pv;  end
            ST_P2:  begin a_x = r_t;   a_y = r_vp;  end
            ST_P3:  begin a_x = r_t;   a_y = r_vv;  end
            ST_P4:  begin a_x = r_t;   a_y = reg_w(r_q); end
            ST_P5:  begin a_x = r_pv;  a_y = r_vv;  end
            ST_P6:  begin a_x = r_vp;  a_y = r_vv;  end
            ST_P7:  begin a_x = r_vv;  a_y = reg_w(r_q); end
            ST_U0:  begin a_x = r_pp;  a_y = reg_w(r_r); end
            ST_U1:  begin a_x = r_z;   a_y = r_pos; a_sub = 1'b1; end
            ST_ACC: begin a_x = m_acc; a_y = m_val; a_sub = (r_mi > 3'd1); end
            default: begin a_x = r_pos; a_y = r_vel; end
        endcase
    end

    assign s_in.ready    = (r_st == ST_IDLE) && !r_ovalid;
    assign m_out.valid    = r_ovalid;
    assign m_out.position = r_opos;
    assign m_out.velocity = r_ovel;
    assign m_out.saturated = r_osat;

    // sequencer
    always_comb begin
        n_st = r_st;
        case (r_st)
            ST_IDLE: if (s_in.valid && s_in.ready)
                         n_st = (s_in.func == FUNC_UPDATE) ? ST_U0 : ST_P0;
            ST_P0, ST_P1, ST_P2, ST_P3, ST_P4, ST_P5, ST_P6: n_st = r_st + 5'd1;
            ST_P7:   n_st = ST_OUT;
            ST_U0:   n_st = ST_U1;
            ST_U1:   n_st = ST_DIV;
            ST_DIV:  if (r_cnt == CW'(1)) n_st = ST_DEND;
            ST_DEND: n_st = r_kidx ? ST_MUL : ST_DIV;
            ST_MUL:  n_st = ST_ACC;
            ST_ACC:  n_st = (r_mi == 3'd5) ? ST_OUT : ST_MUL;
            ST_OUT:  n_st = ST_IDLE;
            default: n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE;
            r_pos <= '0; r_vel <= '0; r_pp <= ONE; r_pv <= '0; r_vp <= '0; r_vv <= ONE;
            r_q <= PROCESS_NOISE_RST; r_r <= MEASURE_NOISE_RST;
            r_ovalid <= 1'b0; r_sat <= 1'b0; r_kidx <= 1'b0; r_mi <= '0; r_cnt <= '0;
        end else begin
            r_st <= n_st;
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_PROCESS_NOISE) r_q <= i_cfg_data;
                if (i_cfg_idx == CFG_MEASURE_NOISE) r_r <= i_cfg_data;
            end
            if (m_out.valid && m_out.ready) r_ovalid <= 1'b0;
            case (r_st)
                ST_IDLE: if (s_in.valid && s_in.ready) begin
                    r_sat <= 1'b0; r_z <= s_in.measurement; r_kidx <= 1'b0; r_mi <= '0;
                end
                ST_P0: begin r_pos <= a_res; r_sat <= r_sat | a_ovf; end
                ST_P1, ST_P2, ST_P3: begin r_t <= a_res; r_sat <= r_sat | a_ovf; end
                ST_P4: begin r_t <= a_res; r_sat <= r_sat | a_ovf; end
                ST_P5: begin r_pv <= a_res; r_sat <= r_sat | a_ovf; end
                ST_P6: begin r_vp <= a_res; r_sat <= r_sat | a_ovf; end
                ST_P7: begin r_vv <= a_res; r_pp <= r_t; r_sat <= r_sat | a_ovf; end
                ST_U0: begin r_s <= a_res; r_sat <= r_sat | a_ovf; end
                ST_U1: begin
                    r_y <= a_res; r_sat <= r_sat | a_ovf;
                    r_num <= NW'(num_mag) << FRAC_BITS; r_dmag <= s_mag;
                    r_qneg <= num_sel[DW-1] ^ r_s[DW-1];
                    r_rem <= '0; r_quo <= '0; r_cnt <= CW'(NW);
                end
                ST_DIV: begin
                    r_num <= r_num << 1;
                    r_cnt <= r_cnt - CW'(1);
                    if (!d_try[DW]) begin r_rem <= d_try; r_quo <= {r_quo[NW-2:0], 1'b1}; end
                    else begin r_rem <= d_sh; r_quo <= {r_quo[NW-2:0], 1'b0}; end
                end
                ST_DEND: begin
                    // zero divisor: zero numerator gives zero, else the signed limit
                    if (r_s == '0) begin
                        if (num_sel == '0) begin
                            if (r_kidx) r_k1 <= '0; else r_k0 <= '0;
                        end else begin
                            r_sat <= 1'b1;
                            if (r_kidx) r_k1 <= num_sel[DW-1] ? LO : HI;
                            else r_k0 <= num_sel[DW-1] ? LO : HI;
                        end
                    end else begin
                        r_sat <= r_sat | q_ovf;
                        if (r_kidx) r_k1 <= q_val; else r_k0 <= q_val;
                    end
                    if (!r_kidx) begin
                        r_kidx <= 1'b1;
                        r_num <= NW'(r_vp[DW-1] ? DW'(-r_vp) : DW'(r_vp)) << FRAC_BITS;
                        r_qneg <= r_vp[DW-1] ^ r_s[DW-1];
                        r_rem <= '0; r_quo <= '0; r_cnt <= CW'(NW);
                    end
                end
                ST_MUL: begin
                    r_prod <= PW'(ma_mag) * PW'(mb_mag);
                    r_pneg <= m_a[DW-1] ^ m_b[DW-1];
                end
                ST_ACC: begin
                    r_sat <= r_sat | m_ovf | a_ovf;
                    r_mi <= r_mi + 3'd1;
                    case (r_mi)
                        3'd0: r_pos <= a_res;
                        3'd1: r_vel <= a_res;
                        3'd2: r_vp <= a_res;
                        3'd3: r_vv <= a_res;
                        3'd4: r_pp <= a_res;
                        3'd5: r_pv <= a_res;
                        default: r_pos <= r_pos;
                    endcase
                end
                ST_OUT: begin
                    r_ovalid <= 1'b1; r_opos <= r_pos; r_ovel <= r_vel; r_osat <= r_sat;
                end
                default: r_sat <= r_sat;
            endcase
        end
    end

`ifndef SYNTH
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st != ST_IDLE) |-> !s_in.ready) else $error("accept while busy");
    a_out_after_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_st) == ST_OUT) else $error("stray result");
    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_DIV) |-> (r_cnt != '0)) else $error("divider overrun");
`endif
endmodule

### bench/kalman_filter_const_velocity_unit_test.sv
// Self-checking bench for the constant-velocity Kalman filter core.
// Depends on kfcv_pkg, kfcv_in_if, kfcv_out_if and the core RTL.
module kalman_filter_const_velocity_unit_test;
    import kfcv_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     DW         = 32;
    localparam longint WORD_MAX   = 64'sd2147483647;
    localparam longint WORD_MIN   = -64'sd2147483648;
    localparam longint CYCLE_CAP  = 3000000;
    localparam int     DRAIN_WAIT = 300;
    localparam int     PHASE_LEN  = 115;

    typedef struct packed {
        logic [DW-1:0] pos;
        logic [DW-1:0] vel;
        logic          sat;
    } kf_state_t;

    typedef struct {
        logic          func;
        logic [DW-1:0] meas;
        bit            typed;
        kf_state_t     res;
    } stim_row_t;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_WIDTH-1:0] i_cfg_idx;
    logic [CFG_WIDTH-1:0] i_cfg_data;

    kfcv_in_if  #(.DW(DW)) in_ch ();
    kfcv_out_if #(.DW(DW)) out_ch ();

    kalman_filter_const_velocity_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .s_in       (in_ch.sink),
        .m_out      (out_ch.source)
    );

    // Filter state as the bench sees it
    longint    kf_pos, kf_vel, kf_pp, kf_pv, kf_vp, kf_vv, kf_q, kf_r;
    bit        kf_clip;
    kf_state_t pending_states[$];
    int        fail_count;
    longint    cycle_count;
    bit        no_stall;
    bit        stim_done;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Run-time cap
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("kalman_filter_const_velocity_unit regression: fail");
            $finish;
        end
    end

    // Saturating fixed-point helpers
    function automatic longint clamp_word(longint v);
        if (v > WORD_MAX) begin
            kf_clip = 1'b1;
            return WORD_MAX;
        end
        if (v < WORD_MIN) begin
            kf_clip = 1'b1;
            return WORD_MIN;
        end
        return v;
    endfunction

    function automatic longint signed_from_mag(bit neg, longint unsigned m);
        longint unsigned lim;
        lim = neg ? 64'd2147483648 : 64'd2147483647;
        if (m > lim) begin
            kf_clip = 1'b1;
            m = lim;
        end
        return neg ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint fx_mul(longint a, longint b);
        longint          p;
        longint unsigned m;
        p = a * b;
        m = (p < 0) ? longint'(-p) : p;
        m = (m + 64'd32768) >> 16;
        return signed_from_mag(p < 0, m);
    endfunction

    function automatic longint fx_div(longint a, longint d);
        longint unsigned ma, md;
        if (d == 0) begin
            if (a == 0) return 0;
            kf_clip = 1'b1;
            return (a < 0) ? WORD_MIN : WORD_MAX;
        end
        ma = ((a < 0) ? -a : a) << 16;
        md = (d < 0) ? -d : d;
        return signed_from_mag((a < 0) != (d < 0), ma / md);
    endfunction

    // Advance the filter one item and return the new state
    function automatic kf_state_t kf_advance(logic func, logic [DW-1:0] meas);
        longint    z, s, k0, k1, y, pp, pv, vp, vv;
        kf_state_t r;
        kf_clip = 1'b0;
        z = longint'($signed(meas));
        if (func == FUNC_PREDICT) begin
            kf_pos = clamp_word(kf_pos + kf_vel);
            pp = clamp_word(kf_pp + kf_pv);
            pp = clamp_word(pp + kf_vp);
            pp = clamp_word(pp + kf_vv);
            pp = clamp_word(pp + kf_q);
            pv = clamp_word(kf_pv + kf_vv);
            vp = clamp_word(kf_vp + kf_vv);
            vv = clamp_word(kf_vv + kf_q);
        end else begin
            s  = clamp_word(kf_pp + kf_r);
            k0 = fx_div(kf_pp, s);
            k1 = fx_div(kf_vp, s);
            y  = clamp_word(z - kf_pos);
            kf_pos = clamp_word(kf_pos + fx_mul(k0, y));
            kf_vel = clamp_word(kf_vel + fx_mul(k1, y));
            pp = clamp_word(kf_pp - fx_mul(k0, kf_pp));
            pv = clamp_word(kf_pv - fx_mul(k0, kf_pv));
            vp = clamp_word(kf_vp - fx_mul(k1, kf_pp));
            vv = clamp_word(kf_vv - fx_mul(k1, kf_pv));
        end
        kf_pp = pp;
        kf_pv = pv;
        kf_vp = vp;
        kf_vv = vv;
        r.pos = kf_pos[DW-1:0];
        r.vel = kf_vel[DW-1:0];
        r.sat = kf_clip;
        return r;
    endfunction

    // Register write, only while the core is idle
    task automatic write_reg(logic [CFG_IDX_WIDTH-1:0] idx, logic [CFG_WIDTH-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == CFG_PROCESS_NOISE) kf_q = longint'(val);
        else kf_r = longint'(val);
    endtask

    // One input transfer; the expectation is queued on acceptance
    task automatic send_item(logic func, logic [DW-1:0] meas, bit typed, kf_state_t res);
        int        gap;
        kf_state_t pred;
        gap = no_stall ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.func        <= func;
        in_ch.measurement <= meas;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        pred = kf_advance(func, meas);
        if (typed) pred = res;
        pending_states = {pending_states, pred};
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (pending_states.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Measurement: mostly near the estimate, some anywhere, a few at the positive limit
    function automatic logic [DW-1:0] pick_meas();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 6) return DW'(clamp_word(kf_pos + longint'($urandom_range(0, 1 << 22))
                                          - (1 << 21)));
        if (sel < 9) return $urandom;
        return sel[0] ? 32'h7fff_ffff : 32'h8000_0000;
    endfunction

    // Result side: random back-pressure and checking
    initial begin
        out_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            int stall;
            stall = no_stall ? 0 : $urandom_range(0, 5);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!out_ch.valid) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            kf_state_t want;
            if (pending_states.size() == 0) begin
                $display("%0t: unexpected result pos=%h vel=%h sat=%b", $time,
                         out_ch.position, out_ch.velocity, out_ch.saturated);
                fail_count++;
            end else begin
                want = pending_states.pop_front();
                if (out_ch.position !== want.pos) begin
                    $display("%0t: position expected %h actual %h", $time, want.pos,
                             out_ch.position);
                    fail_count++;
                end
                if (out_ch.velocity !== want.vel) begin
                    $display("%0t: velocity expected %h actual %h", $time, want.vel,
                             out_ch.velocity);
                    fail_count++;
                end
                if (out_ch.saturated !== want.sat) begin
                    $display("%0t: saturated expected %b actual %b", $time, want.sat,
                             out_ch.saturated);
                    fail_count++;
                end
            end
        end
    end

    // Stimulus
    initial begin
        stim_row_t              rows[$];
        stim_row_t              row;
        logic [CFG_WIDTH-1:0]   q_set[6];
        logic [CFG_WIDTH-1:0]   r_set[6];
        kf_state_t              blank;

        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_idx         = CFG_PROCESS_NOISE;
        i_cfg_data        = '0;
        in_ch.valid       = 1'b0;
        in_ch.func        = FUNC_PREDICT;
        in_ch.measurement = '0;
        fail_count        = 0;
        no_stall          = 1'b0;
        stim_done         = 1'b0;
        blank             = '0;

        kf_pos = 0; kf_vel = 0;
        kf_pp = 65536; kf_pv = 0; kf_vp = 0; kf_vv = 65536;
        kf_q = longint'(PROCESS_NOISE_RST);
        kf_r = longint'(MEASURE_NOISE_RST);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: at rest, measurement extremes, sign flips
        row = '{FUNC_PREDICT, 32'h0, 1'b1, '{32'h0, 32'h0, 1'b0}}; rows = {rows, row};
        row = '{FUNC_UPDATE,  32'h0, 1'b1, '{32'h0, 32'h0, 1'b0}}; rows = {rows, row};
        row = '{FUNC_UPDATE,  32'h7fff_ffff, 1'b0, blank}; rows = {rows, row};
        row = '{FUNC_PREDICT, 32'h7fff_ffff, 1'b0, blank}; rows = {rows, row};
        row = '{FUNC_UPDATE,  32'h8000_0000, 1'b0, blank}; rows = {rows, row};
        row = '{FUNC_UPDATE,  32'h8000_0000, 1'b0, blank}; rows = {rows, row};
        row = '{FUNC_PREDICT, 32'hffff_ffff, 1'b0, blank}; rows = {rows, row};
        row = '{FUNC_UPDATE,  32'hffff_ffff, 1'b0, blank}; rows = {rows, row};
        row = '{FUNC_UPDATE,  32'h0001_0000, 1'b0, blank}; rows = {rows, row};
        row = '{FUNC_PREDICT, 32'h0, 1'b0, blank}; rows = {rows, row};
        row = '{FUNC_PREDICT, 32'h0, 1'b0, blank}; rows = {rows, row};
        row = '{FUNC_UPDATE,  32'h0005_0000, 1'b0, blank}; rows = {rows, row};
        row = '{FUNC_UPDATE,  32'h7fff_ffff, 1'b0, blank}; rows = {rows, row};
        row = '{FUNC_PREDICT, 32'h5555_aaaa, 1'b0, blank}; rows = {rows, row};
        row = '{FUNC_PREDICT, 32'haaaa_5555, 1'b0, blank}; rows = {rows, row};
        row = '{FUNC_UPDATE,  32'h8000_0000, 1'b0, blank}; rows = {rows, row};
        foreach (rows[i]) send_item(rows[i].func, rows[i].meas, rows[i].typed, rows[i].res);
        wait_drained();

        // Noise settings per phase, extremes last so saturation comes late
        q_set = '{31'd6554, 31'd0, 31'd300, 31'd6554, 31'h7fff_ffff, 31'd0};
        r_set = '{31'd65536, 31'd1, 31'd262144, 31'd1, 31'h7fff_ffff, 31'h7fff_ffff};
        q_set[3] = CFG_WIDTH'($urandom_range(0, 32'h0010_0000));
        r_set[3] = CFG_WIDTH'($urandom_range(1, 32'h0100_0000));

        // Random phases; each ends with the sender holding off until drained
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(CFG_PROCESS_NOISE, q_set[ph]);
            write_reg(CFG_MEASURE_NOISE, r_set[ph]);
            no_stall = (ph == 2);
            for (int n = 0; n < PHASE_LEN; n++) begin
                logic func;
                func = 1'($urandom_range(0, 1));
                send_item(func, pick_meas(), 1'b0, blank);
            end
            wait_drained();
        end

        // Drain and report
        no_stall = 1'b0;
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (fail_count == 0 && pending_states.size() == 0) begin
            $display("kalman_filter_const_velocity_unit regression: pass");
        end else begin
            $display("kalman_filter_const_velocity_unit regression: fail");
        end
        $finish;
    end
endmodule

### sim.f
rtl/core/kfcv_pkg.sv
rtl/core/kfcv_in_if.sv
rtl/core/kfcv_out_if.sv
rtl/core/kalman_filter_const_velocity_unit.sv
bench/kalman_filter_const_velocity_unit_test.sv
